// ===== src/rplf_pkg.sv =====
// ----------------------------------------------------------------------------
// rplf_pkg
// Shared types and constants for the record/play LED fade controller.
// ----------------------------------------------------------------------------
package rplf_pkg;

    // command codes
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    localparam logic [7:0] LEVEL_MAX = 8'd255;

    // configuration register indexes
    localparam int         CFG_INDEX_W   = 2;
    localparam int         CFG_DATA_W    = 32;
    localparam logic [1:0] REG_QUICK     = 2'd0;
    localparam logic [1:0] REG_SLOW      = 2'd1;
    localparam logic [1:0] REG_DURATION  = 2'd2;

    localparam logic [7:0]  QUICK_RESET    = 8'd8;
    localparam logic [7:0]  SLOW_RESET     = 8'd1;
    localparam logic [31:0] DURATION_RESET = 32'd5000;

    typedef struct packed {
        logic        command;
        logic        button_level;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic [7:0] button_led_level;
        logic       button_echo;
    } result_t;

    typedef struct packed {
        logic [7:0]  quick_fade_step;
        logic [7:0]  slow_fade_step;
        logic [31:0] play_duration_ms;
    } cfg_t;

endpackage

// ===== src/record_play_led_fade_controller.sv =====
// ----------------------------------------------------------------------------
// record_play_led_fade_controller
// Idle/record/play mode controller with bouncing LED fade.
//
//   channel   direction   handshake             payload
//   item      in          item_valid/stall      command, button_level, time_ms
//   result    out         result_valid/stall    mode, levels, button_echo
//   cfg       in          cfg_write             cfg_index, cfg_data
//
// one word per clock sustained while result_stall is low; an accepted word
// goes from the input register through the core into the result register,
// and a stalled result can hold it in the input register on the way
// reset (rst_n low, async) puts the core in idle mode, red at full, other levels zero
// a stalled result holds the core; the input register then fills and
// item_stall rises
// ----------------------------------------------------------------------------
module record_play_led_fade_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  rplf_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output rplf_pkg::result_t                 result,
    input  logic                              cfg_write,
    input  logic [rplf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rplf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rplf_pkg::cfg_t    cfg;
    rplf_pkg::item_t   held_item;
    rplf_pkg::result_t core_result;
    rplf_pkg::result_t result_reg;
    logic              held_valid;
    logic              result_valid_reg;
    logic              advance;
    logic              fire;

    assign advance = !result_valid_reg || !result_stall;
    assign fire    = advance && held_valid;

    rplf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rplf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rplf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (held_item),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= held_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== src/rplf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rplf_cfg_regs
// Configuration registers: fade steps and play duration.
// ----------------------------------------------------------------------------
module rplf_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rplf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rplf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rplf_pkg::cfg_t                     cfg
);

    rplf_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quick_fade_step  <= rplf_pkg::QUICK_RESET;
            cfg_reg.slow_fade_step   <= rplf_pkg::SLOW_RESET;
            cfg_reg.play_duration_ms <= rplf_pkg::DURATION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rplf_pkg::REG_QUICK:    cfg_reg.quick_fade_step  <= cfg_data[7:0];
                rplf_pkg::REG_SLOW:     cfg_reg.slow_fade_step   <= cfg_data[7:0];
                rplf_pkg::REG_DURATION: cfg_reg.play_duration_ms <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/rplf_in_stage.sv =====
// ----------------------------------------------------------------------------
// rplf_in_stage
// Input register; holds one word until the core can take it.
// ----------------------------------------------------------------------------
module rplf_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  rplf_pkg::item_t item,
    input  logic            advance,
    output logic            held_valid,
    output rplf_pkg::item_t held_item
);

    logic            valid_reg;
    rplf_pkg::item_t item_reg;
    logic            load;

    assign item_stall = valid_reg && !advance;
    assign load       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== src/rplf_core.sv =====
// ----------------------------------------------------------------------------
// rplf_core
// Mode state, fade state and held LED levels; computes one result per word.
// ----------------------------------------------------------------------------
module rplf_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rplf_pkg::item_t   item,
    input  rplf_pkg::cfg_t    cfg,
    output rplf_pkg::result_t result
);

    logic [1:0]        mode_reg,        mode_next;
    logic [7:0]        brightness_reg,  brightness_next;
    logic signed [8:0] fade_step_reg,   fade_step_next;
    logic [31:0]       play_start_reg,  play_start_next;
    logic [7:0]        green_reg,       green_next;
    logic [7:0]        red_reg,         red_next;
    logic [7:0]        button_led_reg,  button_led_next;
    logic              last_button_reg, last_button_next;

    logic [31:0]       elapsed;
    logic signed [9:0] sum;
    logic              do_fade;

    assign elapsed = item.time_ms - play_start_reg;
    assign sum     = $signed({2'b00, brightness_reg})
                   + $signed({fade_step_reg[8], fade_step_reg});

    always_comb
    begin
        mode_next        = mode_reg;
        brightness_next  = brightness_reg;
        fade_step_next   = fade_step_reg;
        play_start_next  = play_start_reg;
        green_next       = green_reg;
        red_next         = red_reg;
        button_led_next  = button_led_reg;
        last_button_next = last_button_reg;
        do_fade          = 1'b0;

        if (item.command == rplf_pkg::CMD_CHECK)
        begin
            last_button_next = item.button_level;
            if (item.button_level && mode_reg == rplf_pkg::MODE_IDLE)
            begin
                mode_next      = rplf_pkg::MODE_REC;
                fade_step_next = $signed({1'b0, cfg.quick_fade_step});
            end
            else if (!item.button_level && mode_reg == rplf_pkg::MODE_REC)
            begin
                mode_next       = rplf_pkg::MODE_PLAY;
                fade_step_next  = '0;
                brightness_next = '0;
                play_start_next = item.time_ms;
            end
            else if (mode_reg == rplf_pkg::MODE_PLAY && elapsed > cfg.play_duration_ms)
            begin
                mode_next      = rplf_pkg::MODE_IDLE;
                fade_step_next = $signed({1'b0, cfg.slow_fade_step});
            end
        end
        else
        begin
            case (mode_reg)
                rplf_pkg::MODE_IDLE:
                begin
                    green_next      = brightness_reg;
                    red_next        = rplf_pkg::LEVEL_MAX;
                    button_led_next = brightness_reg;
                    do_fade         = 1'b1;
                end
                rplf_pkg::MODE_REC:
                begin
                    green_next = rplf_pkg::LEVEL_MAX;
                    red_next   = '0;
                end
                rplf_pkg::MODE_PLAY:
                begin
                    green_next      = brightness_reg;
                    red_next        = brightness_reg;
                    button_led_next = brightness_reg;
                    do_fade         = 1'b1;
                end
                default:
                begin
                    mode_next = rplf_pkg::MODE_IDLE;
                    do_fade   = 1'b1;
                end
            endcase

            if (do_fade)
            begin
                // bounce off either end, clamping to the level range
                if (sum <= 10'sd0 || sum >= 10'sd255)
                begin
                    fade_step_next = -fade_step_reg;
                end
                if (sum < 10'sd0)
                begin
                    brightness_next = '0;
                end
                else if (sum > 10'sd255)
                begin
                    brightness_next = rplf_pkg::LEVEL_MAX;
                end
                else
                begin
                    brightness_next = sum[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rplf_pkg::MODE_IDLE;
            brightness_reg  <= '0;
            fade_step_reg   <= '0;
            play_start_reg  <= '0;
            green_reg       <= '0;
            red_reg         <= rplf_pkg::LEVEL_MAX;
            button_led_reg  <= '0;
            last_button_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            brightness_reg  <= brightness_next;
            fade_step_reg   <= fade_step_next;
            play_start_reg  <= play_start_next;
            green_reg       <= green_next;
            red_reg         <= red_next;
            button_led_reg  <= button_led_next;
            last_button_reg <= last_button_next;
        end
    end

    assign result.mode             = mode_next;
    assign result.green_level      = green_next;
    assign result.red_level        = red_next;
    assign result.button_led_level = button_led_next;
    assign result.button_echo      = last_button_next;

endmodule
